### hw/rtl/xtbd_pkg.sv
// Shared types, constants and character checks for the XML text byte decoder.
package xtbd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO    = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] CP_BOM        = 21'h00FEFF;
    localparam logic [20:0] CP_LINE_FEED  = 21'h00000A;
    localparam logic [20:0] CP_SUPP_BASE  = 21'h010000;
    localparam logic [15:0] UNIT_HIGH_LO  = 16'hD800;
    localparam logic [15:0] UNIT_HIGH_HI  = 16'hDBFF;
    localparam logic [15:0] UNIT_LOW_LO   = 16'hDC00;
    localparam logic [15:0] UNIT_LOW_HI   = 16'hDFFF;

    typedef enum logic [3:0] {
        ST_CHAR       = 4'd0,
        ST_END        = 4'd1,
        ST_BAD_LEAD   = 4'd2,
        ST_TRUNCATED  = 4'd3,
        ST_BAD_CONT   = 4'd4,
        ST_BAD_SCALAR = 4'd5,
        ST_ODD_TAIL   = 4'd6,
        ST_CUT_PAIR   = 4'd7,
        ST_BAD_TRAIL  = 4'd8,
        ST_LONE_TRAIL = 4'd9,
        ST_NON_XML    = 4'd10,
        ST_EMPTY      = 4'd11,
        ST_TOO_LARGE  = 4'd12
    } t_status;

    typedef enum logic [2:0] {
        MODE_AWAIT  = 3'd0,
        MODE_PEND16 = 3'd1,
        MODE_UTF8   = 3'd2,
        MODE_LE     = 3'd3,
        MODE_BE     = 3'd4,
        MODE_ERROR  = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [20:0] code_point;
        logic [31:0] line_number;
        logic [31:0] column_number;
        logic [31:0] char_offset;
        logic        final_result;
    } t_out_beat;

    // One queue entry per byte that yields results: the main result and,
    // when the last byte completes a character, the end-of-document result.
    typedef struct packed {
        t_out_beat prim;
        logic      has_end;
        t_out_beat fin;
    } t_qentry;

    function automatic logic xml_char_ok(input logic [20:0] v);
        xml_char_ok = (v == 21'h9) || (v == 21'hA) || (v == 21'hD) ||
                      (v >= 21'h20 && v <= 21'hD7FF) ||
                      (v >= 21'hE000 && v <= 21'hFFFD) ||
                      (v >= CP_SUPP_BASE && v <= CP_MAX);
    endfunction

    function automatic logic utf8_bad_scalar(input logic [20:0] v, input logic [2:0] len);
        utf8_bad_scalar = (len == 3'd2 && v < 21'h80) ||
                          (len == 3'd3 && v < 21'h800) ||
                          (len == 3'd4 && v < CP_SUPP_BASE) ||
                          (v > CP_MAX) ||
                          (v >= CP_SURR_LO && v <= CP_SURR_HI);
    endfunction

endpackage

### hw/rtl/xtbd_front.sv
// Front end: takes document bytes, tracks encoding and location, and forms result entries.
module xtbd_front #(
    parameter int LOCATION_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_accept,
    input  xtbd_pkg::t_in_beat   i_in_data,
    output logic                 o_push,
    output xtbd_pkg::t_qentry    o_entry
);

    localparam int LW = LOCATION_WIDTH;

    xtbd_pkg::t_mode     r_mode, n_mode, c_mode;
    logic [20:0]         r_partial, n_partial, c_partial;
    logic [2:0]          r_len, n_len, c_len;
    logic [2:0]          r_rcv, n_rcv, c_rcv;
    logic                r_bad, n_bad, c_bad;
    logic [9:0]          r_high, n_high, c_high;
    logic [LW-1:0]       r_sl, n_sl, c_sl;
    logic [LW-1:0]       r_sc, n_sc, c_sc;
    logic [31:0]         r_so, n_so, c_so;
    logic [LW-1:0]       r_line, n_line;
    logic [LW-1:0]       r_col, n_col;
    logic [31:0]         r_bytes, n_bytes, c_bytes;
    logic                r_any, n_any;
    logic [31:0]         r_max, n_max;

    logic                c_fail;
    xtbd_pkg::t_status   c_fail_st;
    logic [31:0]         c_fail_line, c_fail_col, c_fail_off;
    logic                c_char;
    logic [20:0]         c_cp;
    logic                c_finish;

    logic [LW-1:0]       v_line_nx, v_col_nx;
    logic                last;
    logic [7:0]          b;

    assign b    = i_in_data.byte_value;
    assign last = i_in_data.last_byte;

    assign v_line_nx = (c_cp == xtbd_pkg::CP_LINE_FEED) ? r_line + LW'(1) : r_line;
    assign v_col_nx  = (c_cp == xtbd_pkg::CP_LINE_FEED) ? LW'(1) : r_col + LW'(1);

    // Classification of the byte at the front of the input.
    always_comb begin
        logic        v_utf8;
        logic        v_utf16;
        logic        v_badlead;
        logic        v_cand;
        logic [20:0] v_cand_cp;
        logic [15:0] v_unit;

        v_utf8    = 1'b0;
        v_utf16   = 1'b0;
        v_badlead = 1'b0;
        v_cand    = 1'b0;
        v_cand_cp = '0;
        v_unit    = '0;

        c_mode      = r_mode;
        c_partial   = r_partial;
        c_len       = r_len;
        c_rcv       = r_rcv;
        c_bad       = r_bad;
        c_high      = r_high;
        c_sl        = r_sl;
        c_sc        = r_sc;
        c_so        = r_so;
        c_bytes     = r_bytes;
        c_fail      = 1'b0;
        c_fail_st   = xtbd_pkg::ST_BAD_LEAD;
        c_fail_line = '0;
        c_fail_col  = '0;
        c_fail_off  = '0;
        c_char      = 1'b0;
        c_cp        = '0;
        c_finish    = 1'b0;

        if (r_mode != xtbd_pkg::MODE_ERROR) begin
            if (r_bytes >= r_max) begin
                c_fail    = 1'b1;
                c_fail_st = xtbd_pkg::ST_TOO_LARGE;
            end else begin
                c_bytes = r_bytes + 32'd1;
                case (r_mode)
                    xtbd_pkg::MODE_AWAIT: begin
                        if (b == 8'hFF || b == 8'hFE) begin
                            if (last) begin
                                c_fail      = 1'b1;
                                c_fail_st   = xtbd_pkg::ST_BAD_LEAD;
                                c_fail_line = 32'd1;
                                c_fail_col  = 32'd1;
                            end else begin
                                c_mode    = xtbd_pkg::MODE_PEND16;
                                c_partial = {13'd0, b};
                            end
                        end else begin
                            c_mode = xtbd_pkg::MODE_UTF8;
                            v_utf8 = 1'b1;
                        end
                    end
                    xtbd_pkg::MODE_PEND16: begin
                        if (r_partial == 21'hFF && b == 8'hFE) begin
                            c_mode = xtbd_pkg::MODE_LE;
                        end else if (r_partial == 21'hFE && b == 8'hFF) begin
                            c_mode = xtbd_pkg::MODE_BE;
                        end else begin
                            c_fail      = 1'b1;
                            c_fail_st   = xtbd_pkg::ST_BAD_LEAD;
                            c_fail_line = 32'd1;
                            c_fail_col  = 32'd1;
                        end
                        if (!c_fail) begin
                            c_partial = '0;
                            c_finish  = last;
                        end
                    end
                    xtbd_pkg::MODE_UTF8: begin
                        v_utf8 = 1'b1;
                    end
                    xtbd_pkg::MODE_LE, xtbd_pkg::MODE_BE: begin
                        v_utf16 = 1'b1;
                    end
                    default: begin
                    end
                endcase

                if (v_utf8) begin
                    if (r_rcv == 3'd0) begin
                        c_sl  = r_line;
                        c_sc  = r_col;
                        c_so  = r_bytes;
                        c_bad = 1'b0;
                        c_rcv = 3'd1;
                        if (!b[7]) begin
                            c_partial = {13'd0, b};
                            c_len     = 3'd1;
                        end else if (b[7:5] == 3'b110 && b[4:0] != 5'd0) begin
                            c_partial = {16'd0, b[4:0]};
                            c_len     = 3'd2;
                        end else if (b[7:4] == 4'b1110) begin
                            c_partial = {17'd0, b[3:0]};
                            c_len     = 3'd3;
                        end else if (b[7:3] == 5'b11110) begin
                            c_partial = {18'd0, b[2:0]};
                            c_len     = 3'd4;
                        end else begin
                            v_badlead = 1'b1;
                        end
                    end else begin
                        if (b[7:6] != 2'b10) begin
                            c_bad = 1'b1;
                        end
                        c_partial = {r_partial[14:0], b[5:0]};
                        c_rcv     = r_rcv + 3'd1;
                    end

                    // Truncation is checked before a bad continuation byte.
                    if (v_badlead) begin
                        c_fail    = 1'b1;
                        c_fail_st = xtbd_pkg::ST_BAD_LEAD;
                    end else if (c_rcv < c_len) begin
                        if (last) begin
                            c_fail    = 1'b1;
                            c_fail_st = xtbd_pkg::ST_TRUNCATED;
                        end
                    end else if (c_bad) begin
                        c_fail    = 1'b1;
                        c_fail_st = xtbd_pkg::ST_BAD_CONT;
                    end else if (xtbd_pkg::utf8_bad_scalar(c_partial, c_len)) begin
                        c_fail    = 1'b1;
                        c_fail_st = xtbd_pkg::ST_BAD_SCALAR;
                    end else if (c_partial == xtbd_pkg::CP_BOM && c_len == 3'd3 &&
                                 c_so == 32'd0) begin
                        c_rcv    = 3'd0;
                        c_len    = 3'd0;
                        c_finish = last;
                    end else begin
                        v_cand    = 1'b1;
                        v_cand_cp = c_partial;
                    end
                end

                if (v_utf16) begin
                    v_unit = (r_mode == xtbd_pkg::MODE_LE) ? {b, r_partial[7:0]}
                                                           : {r_partial[7:0], b};
                    case (r_rcv)
                        3'd0: begin
                            c_sl      = r_line;
                            c_sc      = r_col;
                            c_so      = r_bytes;
                            c_partial = {13'd0, b};
                            c_rcv     = 3'd1;
                            if (last) begin
                                c_fail    = 1'b1;
                                c_fail_st = xtbd_pkg::ST_ODD_TAIL;
                            end
                        end
                        3'd1: begin
                            if (v_unit >= xtbd_pkg::UNIT_HIGH_LO &&
                                v_unit <= xtbd_pkg::UNIT_HIGH_HI) begin
                                c_high = v_unit[9:0];
                                c_rcv  = 3'd2;
                                if (last) begin
                                    c_fail    = 1'b1;
                                    c_fail_st = xtbd_pkg::ST_CUT_PAIR;
                                end
                            end else if (v_unit >= xtbd_pkg::UNIT_LOW_LO &&
                                         v_unit <= xtbd_pkg::UNIT_LOW_HI) begin
                                c_fail    = 1'b1;
                                c_fail_st = xtbd_pkg::ST_LONE_TRAIL;
                            end else begin
                                v_cand    = 1'b1;
                                v_cand_cp = {5'd0, v_unit};
                            end
                        end
                        3'd2: begin
                            c_partial = {13'd0, b};
                            c_rcv     = 3'd3;
                            if (last) begin
                                c_fail    = 1'b1;
                                c_fail_st = xtbd_pkg::ST_CUT_PAIR;
                            end
                        end
                        default: begin
                            if (v_unit < xtbd_pkg::UNIT_LOW_LO ||
                                v_unit > xtbd_pkg::UNIT_LOW_HI) begin
                                c_fail    = 1'b1;
                                c_fail_st = xtbd_pkg::ST_BAD_TRAIL;
                            end else begin
                                v_cand    = 1'b1;
                                v_cand_cp = xtbd_pkg::CP_SUPP_BASE +
                                            {1'b0, r_high, v_unit[9:0]};
                            end
                        end
                    endcase
                end

                if (v_cand) begin
                    c_rcv = 3'd0;
                    c_len = 3'd0;
                    c_bad = 1'b0;
                    if (!xtbd_pkg::xml_char_ok(v_cand_cp)) begin
                        c_fail    = 1'b1;
                        c_fail_st = xtbd_pkg::ST_NON_XML;
                    end else begin
                        c_char = 1'b1;
                        c_cp   = v_cand_cp;
                    end
                end

                // Every decode error except a bad byte order mark points at the
                // start of the character being decoded.
                if (c_fail && c_fail_line == 32'd0) begin
                    c_fail_line = 32'(c_sl);
                    c_fail_col  = 32'(c_sc);
                    c_fail_off  = c_so;
                end
            end
        end
    end

    // Next state.
    always_comb begin
        n_mode    = r_mode;
        n_partial = r_partial;
        n_len     = r_len;
        n_rcv     = r_rcv;
        n_bad     = r_bad;
        n_high    = r_high;
        n_sl      = r_sl;
        n_sc      = r_sc;
        n_so      = r_so;
        n_line    = r_line;
        n_col     = r_col;
        n_bytes   = r_bytes;
        n_any     = r_any;
        n_max     = i_cfg_we ? i_cfg_wdata : r_max;
        if (i_accept) begin
            if (last) begin
                // The last byte always closes the document.
                n_mode    = xtbd_pkg::MODE_AWAIT;
                n_partial = '0;
                n_len     = '0;
                n_rcv     = '0;
                n_bad     = 1'b0;
                n_high    = '0;
                n_sl      = '0;
                n_sc      = '0;
                n_so      = '0;
                n_line    = LW'(1);
                n_col     = LW'(1);
                n_bytes   = '0;
                n_any     = 1'b0;
            end else begin
                n_mode    = c_fail ? xtbd_pkg::MODE_ERROR : c_mode;
                n_partial = c_partial;
                n_len     = c_len;
                n_rcv     = c_rcv;
                n_bad     = c_bad;
                n_high    = c_high;
                n_sl      = c_sl;
                n_sc      = c_sc;
                n_so      = c_so;
                n_line    = c_char ? v_line_nx : r_line;
                n_col     = c_char ? v_col_nx : r_col;
                n_bytes   = c_bytes;
                n_any     = r_any | c_char;
            end
        end
    end

    // Result entry for the queue.
    always_comb begin
        o_push  = i_accept && (c_fail || c_char || c_finish);
        o_entry = '0;

        o_entry.fin.status        = xtbd_pkg::ST_END;
        o_entry.fin.code_point    = '0;
        o_entry.fin.line_number   = 32'(v_line_nx);
        o_entry.fin.column_number = 32'(v_col_nx);
        o_entry.fin.char_offset   = c_bytes;
        o_entry.fin.final_result  = 1'b1;
        o_entry.has_end           = c_char && last;

        if (c_fail) begin
            o_entry.prim.status        = c_fail_st;
            o_entry.prim.code_point    = '0;
            o_entry.prim.line_number   = c_fail_line;
            o_entry.prim.column_number = c_fail_col;
            o_entry.prim.char_offset   = c_fail_off;
            o_entry.prim.final_result  = 1'b1;
        end else if (c_char) begin
            o_entry.prim.status        = xtbd_pkg::ST_CHAR;
            o_entry.prim.code_point    = c_cp;
            o_entry.prim.line_number   = 32'(c_sl);
            o_entry.prim.column_number = 32'(c_sc);
            o_entry.prim.char_offset   = c_so;
            o_entry.prim.final_result  = 1'b0;
        end else begin
            o_entry.prim.status        = r_any ? xtbd_pkg::ST_END : xtbd_pkg::ST_EMPTY;
            o_entry.prim.code_point    = '0;
            o_entry.prim.line_number   = 32'(r_line);
            o_entry.prim.column_number = 32'(r_col);
            o_entry.prim.char_offset   = c_bytes;
            o_entry.prim.final_result  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= xtbd_pkg::MODE_AWAIT;
            r_partial <= '0;
            r_len     <= '0;
            r_rcv     <= '0;
            r_bad     <= 1'b0;
            r_high    <= '0;
            r_sl      <= '0;
            r_sc      <= '0;
            r_so      <= '0;
            r_line    <= LW'(1);
            r_col     <= LW'(1);
            r_bytes   <= '0;
            r_any     <= 1'b0;
            r_max     <= '1;
        end else begin
            r_mode    <= n_mode;
            r_partial <= n_partial;
            r_len     <= n_len;
            r_rcv     <= n_rcv;
            r_bad     <= n_bad;
            r_high    <= n_high;
            r_sl      <= n_sl;
            r_sc      <= n_sc;
            r_so      <= n_so;
            r_line    <= n_line;
            r_col     <= n_col;
            r_bytes   <= n_bytes;
            r_any     <= n_any;
            r_max     <= n_max;
        end
    end

endmodule

### hw/rtl/xtbd_queue.sv
// Short result queue between the byte front end and the output stage.
module xtbd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  xtbd_pkg::t_qentry i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_nonempty,
    output xtbd_pkg::t_qentry o_head
);

    xtbd_pkg::t_qentry          r_mem [xtbd_pkg::QUEUE_DEPTH];
    logic [xtbd_pkg::QPTR_W-1:0] r_wr, n_wr;
    logic [xtbd_pkg::QPTR_W-1:0] r_rd, n_rd;
    logic [xtbd_pkg::QPTR_W:0]   r_count, n_count;

    localparam logic [xtbd_pkg::QPTR_W-1:0] PTR_LAST =
        xtbd_pkg::QPTR_W'(xtbd_pkg::QUEUE_DEPTH - 1);

    assign o_full     = (r_count == (xtbd_pkg::QPTR_W + 1)'(xtbd_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

### hw/rtl/xtbd_back.sv
// Output stage: unpacks queue entries into result beats held in an output register.
module xtbd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_nonempty,
    input  xtbd_pkg::t_qentry    i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output xtbd_pkg::t_out_beat  o_out_data
);

    logic                 r_valid, n_valid;
    logic                 r_sub, n_sub;
    xtbd_pkg::t_out_beat  r_data, n_data;
    logic                 load;

    assign load = i_nonempty && (!r_valid || !i_out_stall);

    always_comb begin
        n_data  = r_data;
        n_sub   = r_sub;
        o_pop   = 1'b0;
        n_valid = load || (r_valid && i_out_stall);
        if (load) begin
            // An entry with an end result gives two beats: the character first.
            if (i_head.has_end && !r_sub) begin
                n_data = i_head.prim;
                n_sub  = 1'b1;
            end else begin
                n_data = r_sub ? i_head.fin : i_head.prim;
                n_sub  = 1'b0;
                o_pop  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

### hw/rtl/xml_text_byte_decoder.sv
// XML text byte decoder: one byte per beat in, decoded characters with location out.
// The decoder accepts one document byte per clock cycle while the queue is not
// full and produces at most one result beat per cycle. A byte is decoded in the
// cycle it is accepted; its results pass through a four-entry queue and an
// output register. A last byte that completes a character yields two beats (the
// character, then the end result); every other byte yields zero or one. The
// input stalls only when the queue is full, which happens when the output side
// has been stalled or when many last bytes that complete characters arrive back
// to back. The encoding is chosen by the first bytes of each document (UTF-8 by
// default, UTF-16 LE or BE after FF FE or FE FF), and the block returns to its
// start state after each last byte. The document size limit may be written only
// while the decoder is idle.
module xml_text_byte_decoder #(
    parameter int LOCATION_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  xtbd_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output xtbd_pkg::t_out_beat  o_out_data
);

    logic               accept;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_nonempty;
    xtbd_pkg::t_qentry  entry;
    xtbd_pkg::t_qentry  head;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    xtbd_front #(
        .LOCATION_WIDTH(LOCATION_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_in_data   (i_in_data),
        .o_push      (push),
        .o_entry     (entry)
    );

    xtbd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (entry),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head)
    );

    xtbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (q_nonempty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### hw/rtl/xtbd_checker.sv
// Port-level checks on the decoder's result beats, bound to the top level.
module xtbd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_stall,
    input xtbd_pkg::t_out_beat  i_out_data
);

    // A stalled result beat stays in place unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("result beat changed while stalled");

    // Only character beats are not final.
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_data.status == xtbd_pkg::ST_CHAR) ==
                         !i_out_data.final_result))
        else $error("final flag does not match status");

    // Non-character beats carry no code point.
    a_cp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status != xtbd_pkg::ST_CHAR |->
            i_out_data.code_point == 21'd0)
        else $error("code point on a non-character beat");

    // A size-limit error has no location.
    a_size_loc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status == xtbd_pkg::ST_TOO_LARGE |->
            i_out_data.line_number == 32'd0 && i_out_data.column_number == 32'd0 &&
            i_out_data.char_offset == 32'd0)
        else $error("size-limit error carries a location");

endmodule

bind xml_text_byte_decoder xtbd_checker u_xtbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

### tb/xtbd_decode_check.sv
// Checker for the XML text byte decoder: predicts every result beat from the accepted bytes and compares.
module xtbd_decode_check (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  xtbd_pkg::t_in_beat   i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  xtbd_pkg::t_out_beat  i_out_data,
    output int                   o_mismatches,
    output int                   o_pending
);

    logic [31:0] size_limit;

    xtbd_pkg::t_mode mode;
    logic [20:0] acc;
    int          seq_len;
    int          seq_got;
    logic        bad_cont;
    logic [15:0] high_unit;
    logic [31:0] start_line;
    logic [31:0] start_col;
    logic [31:0] start_off;
    logic [31:0] cur_line;
    logic [31:0] cur_col;
    logic [31:0] doc_bytes;
    logic        any_char;

    xtbd_pkg::t_out_beat expected_beats[$];

    function automatic string show(xtbd_pkg::t_out_beat r);
        return $sformatf("status %0d cp %h line %0d col %0d offset %0d final %0b",
                         r.status, r.code_point, r.line_number, r.column_number,
                         r.char_offset, r.final_result);
    endfunction

    function automatic logic is_xml_char(logic [20:0] v);
        return v == 21'h9 || v == 21'hA || v == 21'hD ||
               (v >= 21'h20 && v <= 21'hD7FF) ||
               (v >= 21'hE000 && v <= 21'hFFFD) ||
               (v >= 21'h10000 && v <= 21'h10FFFF);
    endfunction

    task automatic clear_document();
        mode       = xtbd_pkg::MODE_AWAIT;
        acc        = '0;
        seq_len    = 0;
        seq_got    = 0;
        bad_cont   = 1'b0;
        high_unit  = '0;
        start_line = '0;
        start_col  = '0;
        start_off  = '0;
        cur_line   = 32'd1;
        cur_col    = 32'd1;
        doc_bytes  = '0;
        any_char   = 1'b0;
    endtask

    task automatic emit(xtbd_pkg::t_status st, logic [20:0] cp, logic [31:0] ln,
                        logic [31:0] col, logic [31:0] off, logic fin);
        xtbd_pkg::t_out_beat r;
        r.status        = st;
        r.code_point    = cp;
        r.line_number   = ln;
        r.column_number = col;
        r.char_offset   = off;
        r.final_result  = fin;
        expected_beats = {expected_beats, r};
    endtask

    // An error ends the document: the rest of its bytes are dropped.
    task automatic raise(xtbd_pkg::t_status st, logic [31:0] ln, logic [31:0] col,
                         logic [31:0] off, logic last);
        emit(st, '0, ln, col, off, 1'b1);
        if (last) clear_document();
        else mode = xtbd_pkg::MODE_ERROR;
    endtask

    task automatic raise_at_char(xtbd_pkg::t_status st, logic last);
        raise(st, start_line, start_col, start_off, last);
    endtask

    task automatic close_document();
        emit(any_char ? xtbd_pkg::ST_END : xtbd_pkg::ST_EMPTY, '0, cur_line, cur_col,
             doc_bytes, 1'b1);
        clear_document();
    endtask

    task automatic take_char(logic [20:0] v, logic last);
        seq_got  = 0;
        seq_len  = 0;
        bad_cont = 1'b0;
        if (!is_xml_char(v)) begin
            raise_at_char(xtbd_pkg::ST_NON_XML, last);
            return;
        end
        emit(xtbd_pkg::ST_CHAR, v, start_line, start_col, start_off, 1'b0);
        any_char = 1'b1;
        if (v == xtbd_pkg::CP_LINE_FEED) begin
            cur_line = cur_line + 32'd1;
            cur_col  = 32'd1;
        end else begin
            cur_col = cur_col + 32'd1;
        end
        if (last) close_document();
    endtask

    task automatic utf8_byte(logic [7:0] b, logic [31:0] off, logic last);
        logic [20:0] v;
        if (seq_got == 0) begin
            start_line = cur_line;
            start_col  = cur_col;
            start_off  = off;
            bad_cont   = 1'b0;
            if (b < 8'h80) begin
                acc = {13'b0, b};
                seq_len = 1;
            end else if (b[7:5] == 3'b110 && b[4:0] != 5'd0) begin
                acc = {16'b0, b[4:0]};
                seq_len = 2;
            end else if (b[7:4] == 4'b1110) begin
                acc = {17'b0, b[3:0]};
                seq_len = 3;
            end else if (b[7:3] == 5'b11110) begin
                acc = {18'b0, b[2:0]};
                seq_len = 4;
            end else begin
                raise_at_char(xtbd_pkg::ST_BAD_LEAD, last);
                return;
            end
            seq_got = 1;
        end else begin
            if (b[7:6] != 2'b10) bad_cont = 1'b1;
            acc = {acc[14:0], b[5:0]};
            seq_got = seq_got + 1;
        end

        // A document that ends inside a sequence is truncated, even after a bad byte.
        if (seq_got < seq_len) begin
            if (last) raise_at_char(xtbd_pkg::ST_TRUNCATED, last);
            return;
        end
        v = acc;
        if (bad_cont) begin
            raise_at_char(xtbd_pkg::ST_BAD_CONT, last);
            return;
        end
        if ((seq_len == 2 && v < 21'h80) || (seq_len == 3 && v < 21'h800) ||
            (seq_len == 4 && v < 21'h10000) || v > 21'h10FFFF ||
            (v >= 21'hD800 && v <= 21'hDFFF)) begin
            raise_at_char(xtbd_pkg::ST_BAD_SCALAR, last);
            return;
        end
        if (v == xtbd_pkg::CP_BOM && seq_len == 3 && start_off == 32'd0) begin
            seq_got = 0;
            seq_len = 0;
            if (last) close_document();
            return;
        end
        take_char(v, last);
    endtask

    task automatic utf16_byte(logic [7:0] b, logic [31:0] off, logic little, logic last);
        logic [15:0] unit;
        unit = little ? {b, acc[7:0]} : {acc[7:0], b};
        case (seq_got)
            0: begin
                start_line = cur_line;
                start_col  = cur_col;
                start_off  = off;
                acc        = {13'b0, b};
                seq_got    = 1;
                if (last) raise_at_char(xtbd_pkg::ST_ODD_TAIL, last);
            end
            1: begin
                if (unit >= xtbd_pkg::UNIT_HIGH_LO && unit <= xtbd_pkg::UNIT_HIGH_HI) begin
                    high_unit = unit;
                    seq_got   = 2;
                    if (last) raise_at_char(xtbd_pkg::ST_CUT_PAIR, last);
                end else if (unit >= xtbd_pkg::UNIT_LOW_LO &&
                             unit <= xtbd_pkg::UNIT_LOW_HI) begin
                    raise_at_char(xtbd_pkg::ST_LONE_TRAIL, last);
                end else begin
                    take_char({5'b0, unit}, last);
                end
            end
            2: begin
                acc     = {13'b0, b};
                seq_got = 3;
                if (last) raise_at_char(xtbd_pkg::ST_CUT_PAIR, last);
            end
            default: begin
                if (unit < xtbd_pkg::UNIT_LOW_LO || unit > xtbd_pkg::UNIT_LOW_HI)
                    raise_at_char(xtbd_pkg::ST_BAD_TRAIL, last);
                else
                    take_char(21'h10000 + {1'b0, high_unit[9:0], unit[9:0]}, last);
            end
        endcase
    endtask

    task automatic decode_byte(xtbd_pkg::t_in_beat d);
        logic [31:0] off;
        if (mode == xtbd_pkg::MODE_ERROR) begin
            if (d.last_byte) clear_document();
            return;
        end
        if ({1'b0, doc_bytes} + 33'd1 > {1'b0, size_limit}) begin
            raise(xtbd_pkg::ST_TOO_LARGE, '0, '0, '0, d.last_byte);
            return;
        end
        off       = doc_bytes;
        doc_bytes = doc_bytes + 32'd1;
        case (mode)
            xtbd_pkg::MODE_AWAIT: begin
                if (d.byte_value == 8'hFF || d.byte_value == 8'hFE) begin
                    if (d.last_byte) begin
                        raise(xtbd_pkg::ST_BAD_LEAD, 32'd1, 32'd1, 32'd0, d.last_byte);
                    end else begin
                        mode = xtbd_pkg::MODE_PEND16;
                        acc  = {13'b0, d.byte_value};
                    end
                end else begin
                    mode = xtbd_pkg::MODE_UTF8;
                    utf8_byte(d.byte_value, off, d.last_byte);
                end
            end
            xtbd_pkg::MODE_PEND16: begin
                if (acc[7:0] == 8'hFF && d.byte_value == 8'hFE) begin
                    mode = xtbd_pkg::MODE_LE;
                end else if (acc[7:0] == 8'hFE && d.byte_value == 8'hFF) begin
                    mode = xtbd_pkg::MODE_BE;
                end else begin
                    raise(xtbd_pkg::ST_BAD_LEAD, 32'd1, 32'd1, 32'd0, d.last_byte);
                    return;
                end
                acc = '0;
                if (d.last_byte) close_document();
            end
            xtbd_pkg::MODE_UTF8: utf8_byte(d.byte_value, off, d.last_byte);
            xtbd_pkg::MODE_LE:   utf16_byte(d.byte_value, off, 1'b1, d.last_byte);
            default:             utf16_byte(d.byte_value, off, 1'b0, d.last_byte);
        endcase
    endtask

    task automatic check_beat(xtbd_pkg::t_out_beat got);
        xtbd_pkg::t_out_beat want;
        if (expected_beats.size() == 0) begin
            o_mismatches++;
            if (o_mismatches <= 10)
                $display("checker: result beat with none expected: %s", show(got));
            return;
        end
        want = expected_beats.pop_front();
        if (got.status !== want.status || got.code_point !== want.code_point ||
            got.line_number !== want.line_number ||
            got.column_number !== want.column_number ||
            got.char_offset !== want.char_offset ||
            got.final_result !== want.final_result) begin
            o_mismatches++;
            if (o_mismatches <= 10)
                $display("checker: mismatch\n  expected %s\n  actual   %s",
                         show(want), show(got));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_document();
            size_limit = 32'hFFFF_FFFF;
            expected_beats.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_we) size_limit = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) check_beat(i_out_data);
            if (i_in_valid && !i_in_stall) decode_byte(i_in_data);
        end
        o_pending = expected_beats.size();
    end

endmodule

### tb/testbench.sv
// Top of the XML text byte decoder testbench: clock, reset, byte stimulus and verdict.
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 100;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [31:0]         cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    xtbd_pkg::t_in_beat  in_data;
    logic                out_valid;
    logic                out_stall;
    xtbd_pkg::t_out_beat out_data;
    logic                hold_req;
    int                  mismatches;
    int                  pending;
    int                  idle_cycles;

    xtbd_pkg::t_in_beat  doc_q[$];

    // Directed documents, {last, byte}.
    logic [8:0] directed_bytes[26] = '{
        9'h0EF, 9'h0BB, 9'h0BF, 9'h0E2, 9'h082, 9'h0AC, 9'h00A,
        9'h0F0, 9'h09F, 9'h098, 9'h180,
        9'h0FF, 9'h0FE, 9'h03D, 9'h0D8, 9'h000, 9'h1DE,
        9'h0FE, 9'h0FF, 9'h0DC, 9'h000, 9'h141,
        9'h0E2, 9'h141,
        9'h1C0,
        9'h1FF
    };

    xml_text_byte_decoder uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    xtbd_decode_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall density that changes per stretch, plus one long hold-off.
    initial begin : receiver
        int   hold_left;
        int   run_left;
        int   stall_pct;
        logic hold_taken;
        out_stall  = 1'b0;
        hold_left  = 0;
        run_left   = 0;
        stall_pct  = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(60, 4);
                    case ($urandom_range(3, 0))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                run_left--;
                out_stall <= ($urandom_range(99, 0) < stall_pct);
            end
        end
    end

    task automatic send_beat(xtbd_pkg::t_in_beat b);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic play_queue();
        int burst;
        while (doc_q.size() > 0) begin
            burst = $urandom_range(24, 1);
            while (burst > 0 && doc_q.size() > 0) begin
                send_beat(doc_q.pop_front());
                burst--;
            end
            if ($urandom_range(3, 0) != 0) begin
                repeat ($urandom_range(8, 1)) begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                end
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_limit(logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // A byte that yields no result may still be in flight when the last beat arrives.
    task automatic next_limit(logic [31:0] value);
        wait_drained();
        repeat (8) @(negedge clk);
        write_limit(value);
    endtask

    task automatic push_byte(logic [7:0] b);
        xtbd_pkg::t_in_beat t;
        t.byte_value = b;
        t.last_byte  = 1'b0;
        doc_q = {doc_q, t};
    endtask

    // Plain UTF-8 encoding at a chosen length, so overlong forms come out too.
    task automatic put_utf8(logic [20:0] v, int len);
        case (len)
            1: push_byte(v[7:0]);
            2: begin
                push_byte({3'b110, v[10:6]});
                push_byte({2'b10, v[5:0]});
            end
            3: begin
                push_byte({4'b1110, v[15:12]});
                push_byte({2'b10, v[11:6]});
                push_byte({2'b10, v[5:0]});
            end
            default: begin
                push_byte({5'b11110, v[20:18]});
                push_byte({2'b10, v[17:12]});
                push_byte({2'b10, v[11:6]});
                push_byte({2'b10, v[5:0]});
            end
        endcase
    endtask

    task automatic put_unit(logic [15:0] u, logic little);
        if (little) begin
            push_byte(u[7:0]);
            push_byte(u[15:8]);
        end else begin
            push_byte(u[15:8]);
            push_byte(u[7:0]);
        end
    endtask

    task automatic add_utf8_char();
        int          pick;
        int          len;
        logic [20:0] v;
        pick = $urandom_range(99, 0);
        len  = 0;
        v    = 21'h41;
        if (pick < 30) begin
            v = 21'($urandom_range('h7E, 'h20));
        end else if (pick < 38) begin
            case ($urandom_range(2, 0))
                0: v = 21'h9;
                1: v = 21'hA;
                default: v = 21'hD;
            endcase
        end else if (pick < 52) begin
            v = 21'($urandom_range('h7FF, 'h80));
        end else if (pick < 66) begin
            v = 21'($urandom_range(1, 0) ? $urandom_range('hD7FF, 'h800)
                                         : $urandom_range('hFFFD, 'hE000));
        end else if (pick < 80) begin
            v = 21'($urandom_range('h10FFFF, 'h10000));
        end else if (pick < 90) begin
            v = 21'($urandom_range('h10FFFF, 'h80));
        end else begin
            case ($urandom_range(8, 0))
                0: begin
                    v   = 21'($urandom_range('h7F, 0));
                    len = $urandom_range(4, 2);
                end
                1: begin
                    v   = 21'($urandom_range('hDFFF, 'hD800));
                    len = 3;
                end
                2: begin
                    v   = 21'($urandom_range('h1FFFFF, 'h110000));
                    len = 4;
                end
                3: v = 21'($urandom_range('h1F, 0));
                4: v = 21'($urandom_range('hFFFF, 'hFFFE));
                5: begin
                    push_byte(8'($urandom_range('hBF, 'h80)));
                    return;
                end
                6: begin
                    push_byte(8'($urandom_range('hFF, 'hF8)));
                    return;
                end
                7: begin
                    push_byte(8'hE3);
                    push_byte(8'($urandom_range(255, 0)));
                    push_byte(8'($urandom_range('hBF, 'h80)));
                    return;
                end
                default: begin
                    // A four-byte sequence missing its final byte.
                    push_byte(8'hF1);
                    push_byte(8'($urandom_range('hBF, 'h80)));
                    push_byte(8'($urandom_range('hBF, 'h80)));
                    return;
                end
            endcase
        end
        if (len == 0)
            len = (v < 21'h80) ? 1 : (v < 21'h800) ? 2 : (v < 21'h10000) ? 3 : 4;
        put_utf8(v, len);
    endtask

    task automatic add_utf16_char(logic little);
        int          pick;
        logic [20:0] v;
        pick = $urandom_range(99, 0);
        if (pick < 30) begin
            v = 21'($urandom_range('h7E, 'h20));
        end else if (pick < 38) begin
            v = 21'hA;
        end else if (pick < 60) begin
            v = 21'($urandom_range(1, 0) ? $urandom_range('hD7FF, 'h800)
                                         : $urandom_range('hFFFD, 'hE000));
        end else if (pick < 80) begin
            v = 21'($urandom_range('h10FFFF, 'h10000));
        end else if (pick < 90) begin
            v = 21'($urandom_range('hFFFF, 0));
        end else begin
            case ($urandom_range(3, 0))
                0: put_unit(16'($urandom_range('hDFFF, 'hDC00)), little);
                1: begin
                    put_unit(16'($urandom_range('hDBFF, 'hD800)), little);
                    put_unit(16'($urandom_range('hD7FF, 0)), little);
                end
                2: put_unit(16'($urandom_range(1, 0) ? $urandom_range('hFFFF, 'hFFFE)
                                                     : $urandom_range(8, 0)), little);
                default: put_unit(16'($urandom_range('hDBFF, 'hD800)), little);
            endcase
            return;
        end
        if (v >= 21'h10000) begin
            v = v - 21'h10000;
            put_unit(16'hD800 | {6'b0, v[19:10]}, little);
            put_unit(16'hDC00 | {6'b0, v[9:0]}, little);
        end else begin
            put_unit(v[15:0], little);
        end
    endtask

    task automatic gen_document();
        int                 first;
        int                 kind;
        int                 nchars;
        int                 idx;
        logic               little;
        xtbd_pkg::t_in_beat tmp;
        first  = doc_q.size();
        kind   = $urandom_range(19, 0);
        nchars = ($urandom_range(7, 0) == 0) ? $urandom_range(12, 0) : $urandom_range(5, 1);
        if (kind < 2) begin
            repeat ($urandom_range(6, 1)) push_byte(8'($urandom_range(255, 0)));
        end else if (kind < 12) begin
            if (kind < 5) begin
                push_byte(8'hEF);
                push_byte(8'hBB);
                push_byte(8'hBF);
            end
            repeat (nchars) add_utf8_char();
        end else begin
            little = (kind < 16);
            push_byte(little ? 8'hFF : 8'hFE);
            push_byte(little ? 8'hFE : 8'hFF);
            repeat (nchars) add_utf16_char(little);
        end
        if (doc_q.size() == first) push_byte(8'h41);

        // Cutting the tail makes documents end inside a sequence or a pair.
        if ($urandom_range(5, 0) == 0 && doc_q.size() > first + 2) begin
            doc_q = doc_q[0:$-1];
            if ($urandom_range(1, 0) == 1) doc_q = doc_q[0:$-1];
        end
        if ($urandom_range(15, 0) == 0) begin
            idx = $urandom_range(doc_q.size() - 1, first);
            tmp = doc_q[idx];
            tmp.byte_value = 8'($urandom_range(255, 0));
            doc_q[idx] = tmp;
        end
        tmp = doc_q[doc_q.size() - 1];
        tmp.last_byte = 1'b1;
        doc_q[doc_q.size() - 1] = tmp;
    endtask

    task automatic fill_docs(int target);
        while (doc_q.size() < target) gen_document();
    endtask

    initial begin : stimulus
        xtbd_pkg::t_in_beat b;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        hold_req    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_limit(32'hFFFF_FFFF);
        foreach (directed_bytes[k]) begin
            b.byte_value = directed_bytes[k][7:0];
            b.last_byte  = directed_bytes[k][8];
            doc_q = {doc_q, b};
        end
        fill_docs(200);
        play_queue();

        // Smallest limit: every document longer than one byte overflows.
        next_limit(32'd1);
        fill_docs(60);
        play_queue();

        next_limit($urandom_range(10, 2));
        fill_docs(60);
        play_queue();
        wait_drained();
        fill_docs(60);
        play_queue();

        next_limit($urandom_range(40, 11));
        fill_docs(100);
        play_queue();

        next_limit(32'hFFFF_FFFF);
        fill_docs(50);
        play_queue();
        hold_req = 1'b1;
        fill_docs(100);
        play_queue();

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
